// File: hw/rtl/tfvc_pkg.sv
// package: widths, constants and cordic table for the velocity command unit
`default_nettype none
package tfvc_pkg;
    localparam int CORDIC_STAGES = 14;
    localparam int TABLE_LEN     = 20;
    localparam int NSTG = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int CW   = 28;  // cordic coordinate width
    localparam int ZW   = 24;  // angle width, q.20
    localparam logic signed [ZW-1:0] PI_Q20 = 24'sd3294199;
    localparam logic signed [16:0] ANG_PI   = 17'sd12868;
    localparam logic [16:0] INV_GAIN        = 17'd39797;

    typedef enum logic [2:0] {
        REG_MAX_ANGULAR = 3'd0,
        REG_MAX_LINEAR  = 3'd1,
        REG_STOP_RADIUS = 3'd2,
        REG_TURN_STOP   = 3'd3,
        REG_HEADING_REF = 3'd4
    } reg_idx_t;

    function automatic logic signed [ZW-1:0] atan_tab(input int i);
        case (i)
            0: atan_tab = 24'sd823550;   1: atan_tab = 24'sd486170;
            2: atan_tab = 24'sd256879;   3: atan_tab = 24'sd130396;
            4: atan_tab = 24'sd65451;    5: atan_tab = 24'sd32757;
            6: atan_tab = 24'sd16383;    7: atan_tab = 24'sd8192;
            8: atan_tab = 24'sd4096;     9: atan_tab = 24'sd2048;
            10: atan_tab = 24'sd1024;    11: atan_tab = 24'sd512;
            12: atan_tab = 24'sd256;     13: atan_tab = 24'sd128;
            14: atan_tab = 24'sd64;      15: atan_tab = 24'sd32;
            16: atan_tab = 24'sd16;      17: atan_tab = 24'sd8;
            18: atan_tab = 24'sd4;       19: atan_tab = 24'sd2;
            default: atan_tab = '0;
        endcase
    endfunction
endpackage
`default_nettype wire

// File: hw/rtl/target_follow_velocity_command_unit.sv
// top level: pipelined go-to-goal velocity command unit
// channel | dir | width | content
// s_axis  | in  | 32+1u | tdata {target_y, target_x}, tuser target_valid
// m_axis  | out | 32+1u | tdata {angular_vel, linear_vel}, tuser target_lost
// cfg     | in  | 3+15  | register index, write data
// one item per cycle while m_axis does not stall; the vectoring and rotation
// cordic chains do one micro-rotation per register stage.
// rst_n clears all valid bits and loads register reset values.
// a stall at m_axis freezes the whole pipe, nothing is dropped.
`default_nettype none
module target_follow_velocity_command_unit
    import tfvc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // target_x[15:0], target_y[31:16]
    input  wire logic        s_axis_tuser,   // target_valid
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // linear_vel[15:0], angular_vel[30:16], 0
    output logic             m_axis_tuser,   // target_lost
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [14:0] cfg_data
);
    localparam int NP = 2 * NSTG + 5;

    logic [13:0] max_ang_reg;
    logic [14:0] max_lin_reg, stop_rad_reg;
    logic [13:0] turn_lim_reg;
    logic signed [14:0] head_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_ang_reg  <= 14'd4096;
            max_lin_reg  <= 15'd56;
            stop_rad_reg <= 15'd128;
            turn_lim_reg <= 14'd1229;
            head_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_MAX_ANGULAR: max_ang_reg  <= cfg_data[13:0];
                REG_MAX_LINEAR:  max_lin_reg  <= cfg_data;
                REG_STOP_RADIUS: stop_rad_reg <= cfg_data;
                REG_TURN_STOP:   turn_lim_reg <= cfg_data[13:0];
                REG_HEADING_REF: head_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic [NP-1:0] vld_reg;
    assign en = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[NP-1];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NP-2:0], s_axis_tvalid};
    end

    // stage 0: fold left half-plane
    logic signed [CW-1:0] x0_reg, y0_reg;
    logic signed [ZW-1:0] base0_reg;
    logic flip0_reg, ok0_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin : s0
            logic signed [16:0] xi, yi;
            logic zero;
            xi = 17'(signed'(s_axis_tdata[15:0]));
            yi = 17'(signed'(s_axis_tdata[31:16]));
            zero = (xi == 0) && (yi == 0);
            ok0_reg   <= s_axis_tuser;
            flip0_reg <= xi[16] && !zero;
            if (xi[16])
            begin
                base0_reg <= yi[16] ? -PI_Q20 : PI_Q20;
                xi = -xi;
                yi = -yi;
            end
            else
                base0_reg <= '0;
            x0_reg <= CW'(xi) <<< 8;
            y0_reg <= CW'(yi) <<< 8;
        end
    end

    // vectoring chain
    logic signed [CW-1:0] vx_reg [NSTG+1];
    logic signed [CW-1:0] vy_reg [NSTG+1];
    logic signed [ZW-1:0] vz_reg [NSTG+1];
    logic signed [ZW-1:0] vb_reg [NSTG+1];
    logic vf_reg [NSTG+1];
    logic vo_reg [NSTG+1];
    always_comb
    begin
        vx_reg[0] = x0_reg; vy_reg[0] = y0_reg; vz_reg[0] = '0;
        vb_reg[0] = base0_reg; vf_reg[0] = flip0_reg; vo_reg[0] = ok0_reg;
    end
    for (genvar i = 0; i < NSTG; i++)
    begin : g_vec
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!vy_reg[i][CW-1])
                begin
                    vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] + atan_tab(i);
                end
                else
                begin
                    vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] - atan_tab(i);
                end
                vb_reg[i+1] <= vb_reg[i];
                vf_reg[i+1] <= vf_reg[i];
                vo_reg[i+1] <= vo_reg[i];
            end
        end
    end

    // stage a: gain product, angle round, angular clamp
    logic signed [CW+17:0] rprod_reg;
    logic signed [16:0] ang_a_reg;
    logic signed [ZW-1:0] za_reg;
    logic fa_reg, oa_reg, stop_a_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin : sa
            logic signed [ZW:0] s;
            logic signed [16:0] phi, th, lim, a;
            logic signed [ZW-1:0] zv;
            // x stays positive for any nonzero target, so zero length marks the origin
            zv = (vx_reg[NSTG] == '0) ? '0 : vz_reg[NSTG];
            s = ZW'(vb_reg[NSTG]) + (ZW+1)'(zv) + 25'sd128;
            s = s >>> 8;
            if (s > 25'(ANG_PI)) phi = ANG_PI;
            else if (s < -25'(ANG_PI)) phi = -ANG_PI;
            else phi = 17'(s);
            th = -phi - 17'(head_reg);
            lim = (max_ang_reg > 14'd12868) ? ANG_PI : 17'(signed'({1'b0, max_ang_reg}));
            if (th > lim) a = lim;
            else if (th < -lim) a = -lim;
            else a = th;
            ang_a_reg  <= a;
            stop_a_reg <= (a > 17'(signed'({1'b0, turn_lim_reg})))
                       || (a < -17'(signed'({1'b0, turn_lim_reg})));
            rprod_reg  <= vx_reg[NSTG] * signed'({1'b0, INV_GAIN});
            za_reg <= zv;
            fa_reg <= vf_reg[NSTG];
            oa_reg <= vo_reg[NSTG];
        end
    end

    // stage b: distance, minus stop radius
    logic signed [CW-1:0] rx0_reg;
    logic signed [ZW-1:0] zb_reg;
    logic signed [16:0] ang_b_reg;
    logic fb_reg, ob_reg, stop_b_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin : sb
            logic signed [CW+17:0] t;
            logic signed [19:0] d;
            t = (rprod_reg + (46'sd1 <<< 23)) >>> 24;
            d = 20'(t) - 20'(signed'({1'b0, stop_rad_reg}));
            rx0_reg <= CW'(d) <<< 8;
            zb_reg <= za_reg; ang_b_reg <= ang_a_reg;
            fb_reg <= fa_reg; ob_reg <= oa_reg; stop_b_reg <= stop_a_reg;
        end
    end

    // rotation chain
    logic signed [CW-1:0] rx_reg [NSTG+1];
    logic signed [CW-1:0] ry_reg [NSTG+1];
    logic signed [ZW-1:0] rz_reg [NSTG+1];
    logic signed [16:0] ra_reg [NSTG+1];
    logic rf_reg [NSTG+1];
    logic ro_reg [NSTG+1];
    logic rs_reg [NSTG+1];
    always_comb
    begin
        rx_reg[0] = rx0_reg; ry_reg[0] = '0; rz_reg[0] = zb_reg;
        ra_reg[0] = ang_b_reg; rf_reg[0] = fb_reg; ro_reg[0] = ob_reg;
        rs_reg[0] = stop_b_reg;
    end
    for (genvar i = 0; i < NSTG; i++)
    begin : g_rot
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!rz_reg[i][ZW-1])
                begin
                    rx_reg[i+1] <= rx_reg[i] - (ry_reg[i] >>> i);
                    ry_reg[i+1] <= ry_reg[i] + (rx_reg[i] >>> i);
                    rz_reg[i+1] <= rz_reg[i] - atan_tab(i);
                end
                else
                begin
                    rx_reg[i+1] <= rx_reg[i] + (ry_reg[i] >>> i);
                    ry_reg[i+1] <= ry_reg[i] - (rx_reg[i] >>> i);
                    rz_reg[i+1] <= rz_reg[i] + atan_tab(i);
                end
                ra_reg[i+1] <= ra_reg[i]; rf_reg[i+1] <= rf_reg[i];
                ro_reg[i+1] <= ro_reg[i]; rs_reg[i+1] <= rs_reg[i];
            end
        end
    end

    // stage c: gain product
    logic signed [CW+17:0] lprod_reg;
    logic signed [16:0] ang_c_reg;
    logic fc_reg, oc_reg, stop_c_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lprod_reg <= rx_reg[NSTG] * signed'({1'b0, INV_GAIN});
            ang_c_reg <= ra_reg[NSTG]; fc_reg <= rf_reg[NSTG];
            oc_reg <= ro_reg[NSTG]; stop_c_reg <= rs_reg[NSTG];
        end
    end

    // stage d: round, sign, clamp, output
    logic signed [15:0] lin_reg;
    logic signed [14:0] ang_reg;
    logic lost_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin : sd
            logic signed [CW+17:0] t;
            logic signed [21:0] l, lim;
            t = (lprod_reg + (46'sd1 <<< 23)) >>> 24;
            l = 22'(t);
            if (fc_reg) l = -l;
            lim = 22'(signed'({1'b0, max_lin_reg}));
            if (l > lim) l = lim;
            else if (l < -lim) l = -lim;
            if (!oc_reg)
            begin
                lin_reg <= '0; ang_reg <= '0;
            end
            else
            begin
                lin_reg <= stop_c_reg ? 16'sd0 : 16'(l);
                ang_reg <= 15'(ang_c_reg);
            end
            lost_reg <= !oc_reg;
        end
    end

    assign m_axis_tdata = {1'b0, ang_reg, lin_reg};
    assign m_axis_tuser = lost_reg;
endmodule
`default_nettype wire

// File: hw/rtl/tfvc_checker.sv
// checker: port-level properties of the velocity command unit
`default_nettype none
module tfvc_checker
    import tfvc_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tuser,
    input wire logic        cfg_ready
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed under stall");
    a_lost_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
        else $error("lost target with nonzero command");
    a_ang_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (signed'(m_axis_tdata[30:16]) <= 15'sd12868)
            && (signed'(m_axis_tdata[30:16]) >= -15'sd12868))
        else $error("angular command out of range");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready && cfg_ready)
        else $error("input stalled with empty output");
endmodule

bind target_follow_velocity_command_unit tfvc_checker u_tfvc_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .cfg_ready(cfg_ready)
);
`default_nettype wire

// File: bench/tb_target_follow_velocity_command_unit.sv
// testbench: go-to-goal velocity command unit against a bit-true predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_target_follow_velocity_command_unit;
    import tfvc_pkg::*;

    typedef struct packed {
        logic [15:0] lin;
        logic [14:0] ang;
        logic        lost;
    } cmd_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // target_x[15:0], target_y[31:16]
    logic        s_axis_tuser;   // target_valid
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // linear_vel[15:0], angular_vel[30:16], 0
    logic        m_axis_tuser;   // target_lost
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [14:0] cfg_data;

    target_follow_velocity_command_unit dut (.*);

    // predictor copy of the registers
    longint lim_ang, lim_lin, stop_r, turn_lim, head_ref;
    cmd_t   cmd_q[$];
    int     errors, n_sent, n_recv;
    int     cycles = 0;
    bit     rx_stall_on;

    localparam int LAT = 2 * NSTG + 5;
    localparam int CYCLE_LIMIT = 600000;

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function automatic longint sra(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clampv(longint v, longint l);
        if (v > l) return l;
        if (v < -l) return -l;
        return v;
    endfunction

    function automatic longint atan_q20(int i);
        longint t[20] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                          4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
        return t[i];
    endfunction

    function automatic cmd_t follow_command(logic signed [15:0] tx, logic signed [15:0] ty,
                                            logic ok);
        longint x, y, base, z, r, phi, theta, ang, lin, cx, cy, ox, rx, ry, rz, la, hr;
        bit flip;
        cmd_t c;
        x = tx; y = ty; base = 0; z = 0; r = 0; lin = 0; ang = 0; flip = 0;
        if (ok)
        begin
            if (x < 0)
            begin
                flip = 1;
                base = (y >= 0) ? 3294199 : -3294199;
                x = -x; y = -y;
            end
            if (x != 0 || y != 0)
            begin
                cx = x * 256; cy = y * 256;
                for (int i = 0; i < NSTG; i++)
                begin
                    ox = cx;
                    if (cy >= 0)
                    begin
                        cx += sra(cy, i); cy -= sra(ox, i); z += atan_q20(i);
                    end
                    else
                    begin
                        cx -= sra(cy, i); cy += sra(ox, i); z -= atan_q20(i);
                    end
                end
                r = sra(cx * 39797 + (64'sd1 <<< 23), 24);
            end
            else
            begin
                base = 0; flip = 0;
            end
            phi = clampv(sra(base + z + 128, 8), 12868);
            theta = -phi;
            la = (lim_ang > 12868) ? 12868 : lim_ang;
            hr = head_ref[14] ? head_ref - 32768 : head_ref;
            ang = clampv(theta - hr, la);
            if (ang > turn_lim || ang < -turn_lim) lin = 0;
            else
            begin
                rx = (r - stop_r) * 256; ry = 0; rz = z;
                for (int i = 0; i < NSTG; i++)
                begin
                    ox = rx;
                    if (rz >= 0)
                    begin
                        rx -= sra(ry, i); ry += sra(ox, i); rz -= atan_q20(i);
                    end
                    else
                    begin
                        rx += sra(ry, i); ry -= sra(ox, i); rz += atan_q20(i);
                    end
                end
                lin = sra(rx * 39797 + (64'sd1 <<< 23), 24);
                if (flip) lin = -lin;
                lin = clampv(lin, lim_lin);
            end
        end
        c.lin = lin[15:0];
        c.ang = ang[14:0];
        c.lost = ~ok;
        return c;
    endfunction

    // returns right after the accepting edge; the next call drops tvalid for a gap or sends at once, drain drops tvalid
    task automatic send_target(logic [15:0] tx, logic [15:0] ty, logic ok);
        int gap;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) gap = 0;
        @(negedge clk);
        if (gap != 0)
        begin
            s_axis_tvalid <= 0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {ty, tx};
        s_axis_tuser  <= ok;
        cmd_q.push_back(follow_command(tx, ty, ok));
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        n_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 0;
        while (cmd_q.size() != 0) @(negedge clk);
        repeat (LAT + 4) @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [14:0] v);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_MAX_ANGULAR: lim_ang  = v[13:0];
            REG_MAX_LINEAR:  lim_lin  = v[14:0];
            REG_STOP_RADIUS: stop_r   = v[14:0];
            REG_TURN_STOP:   turn_lim = v[13:0];
            REG_HEADING_REF: head_ref = v[14:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic set_all(int a, int l, int s, int t, int h);
        drain();
        write_reg(REG_MAX_ANGULAR, a[14:0]);
        write_reg(REG_MAX_LINEAR, l[14:0]);
        write_reg(REG_STOP_RADIUS, s[14:0]);
        write_reg(REG_TURN_STOP, t[14:0]);
        write_reg(REG_HEADING_REF, h[14:0]);
    endtask

    task automatic test_directed();
        logic [15:0] v[8] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
                              16'h0100, 16'hFF00, 16'h0080};
        send_target(16'h0000, 16'h0000, 1);
        send_target(16'h1234, 16'h5678, 0);
        send_target(16'h8000, 16'h8000, 1);
        send_target(16'h7FFF, 16'h7FFF, 1);
        send_target(16'h8000, 16'h0000, 1);
        send_target(16'h8000, 16'hFFFF, 1);
        for (int i = 0; i < 8; i++)
            send_target(v[i], v[(i * 3 + 1) % 8], 1);
        send_target(16'h0200, 16'h0010, 1);
        send_target(16'h0200, 16'hFFF0, 1);
        send_target(16'hFE00, 16'h0000, 1);
        send_target(16'h0000, 16'h0200, 1);
        send_target(16'h0000, 16'hFE00, 1);
    endtask

    task automatic test_random(int count);
        logic [15:0] tx, ty;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 3))
                0: begin tx = 16'($urandom); ty = 16'($urandom); end
                1: begin
                    tx = 16'($urandom_range(0, 2047) - 1024);
                    ty = 16'($urandom_range(0, 511) - 256);
                end
                2: begin
                    tx = 16'($urandom_range(0, 4000));
                    ty = 16'($urandom_range(0, 60) - 30);
                end
                default: begin
                    tx = 16'($urandom_range(0, 255) - 128);
                    ty = 16'($urandom_range(0, 255) - 128);
                end
            endcase
            send_target(tx, ty, $urandom_range(0, 9) != 0);
        end
    endtask

    // result sink with random stalls while rx_stall_on is set
    initial
    begin
        cmd_t exp_c, got;
        int stall;
        m_axis_tready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = rx_stall_on ? $urandom_range(0, 19) : 0;
            if (rx_stall_on && $urandom_range(0, 3) == 0) stall = 0;
            if (stall != 0)
            begin
                m_axis_tready <= 0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
            got.lin = m_axis_tdata[15:0];
            got.ang = m_axis_tdata[30:16];
            got.lost = m_axis_tuser;
            n_recv++;
            if (cmd_q.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected beat lin=%h ang=%h lost=%b",
                                           got.lin, got.ang, got.lost);
            end
            else
            begin
                exp_c = cmd_q.pop_front();
                if (got !== exp_c)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch beat %0d: exp lin=%h ang=%h lost=%b got lin=%h ang=%h lost=%b",
                                 n_recv, exp_c.lin, exp_c.ang, exp_c.lost,
                                 got.lin, got.ang, got.lost);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 0; s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
        cfg_valid = 0; cfg_index = 0; cfg_data = 0;
        errors = 0; n_sent = 0; n_recv = 0; rx_stall_on = 1;
        lim_ang = 4096; lim_lin = 56; stop_r = 128; turn_lim = 1229; head_ref = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        test_directed();
        test_random(250);
        set_all(12868, 32767, 0, 12868, 0);
        test_directed();
        test_random(200);
        set_all(16383, 32767, 32767, 16383, 12868);
        test_random(150);
        set_all(0, 0, 0, 0, 15'h4DBC);  // heading -pi
        test_random(100);
        rx_stall_on = 0;
        set_all(3000, 1000, 64, 6000, 500);
        test_random(200);
        rx_stall_on = 1;
        set_all(8000, 20000, 300, 12868, 15'h7E0C);
        test_random(150);
        drain();
        $display("sent %0d targets, checked %0d commands over six register settings",
                 n_sent, n_recv);
        if (errors == 0 && cmd_q.size() == 0)
            $display("Simulation PASSED");
        else
        begin
            $display("%0d mismatches, %0d commands missing", errors, cmd_q.size());
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
